// ===== rtl/fdds_pkg.sv =====
package fdds_pkg;

    // APB register map: register index sits at paddr[2]
    localparam int unsigned ADDR_W = 3;
    localparam logic REG_PHASE_TICKS = 1'b0;
    localparam logic REG_BRIGHTNESS  = 1'b1;

    localparam logic [7:0] PHASE_TICKS_RST = 8'd20;
    localparam logic [2:0] BRIGHTNESS_RST  = 3'd0;

    // Digit positions on the display
    localparam int unsigned DIGITS = 4;

    // Bus commands
    localparam logic [7:0] CMD_DATA = 8'h44;
    localparam logic [7:0] CMD_ADDR = 8'hc0;
    localparam logic [7:0] CMD_DISP = 8'h88;
    localparam logic [7:0] SEG_DOT  = 8'h80;
    localparam logic [7:0] SEG_BLANK = 8'h00;

    localparam logic [7:0] VALUE_MAX = 8'd99;

    // Where the sequencer stands inside a frame
    typedef enum logic [1:0] {
        PH_START,
        PH_BITS,
        PH_STOP
    } t_phase;

    typedef struct packed {
        logic clk_level;
        logic dio_level;
        logic busy_res;
        logic load_refused;
    } t_result;

    function automatic logic [7:0] seg_code(input logic [3:0] digit);
        logic [7:0] code;
        case (digit)
            4'd0:    code = 8'h3f;
            4'd1:    code = 8'h06;
            4'd2:    code = 8'h5b;
            4'd3:    code = 8'h4f;
            4'd4:    code = 8'h66;
            4'd5:    code = 8'h6d;
            4'd6:    code = 8'h7d;
            4'd7:    code = 8'h07;
            4'd8:    code = 8'h7f;
            4'd9:    code = 8'h6f;
            default: code = SEG_BLANK;
        endcase
        return code;
    endfunction

endpackage

// ===== rtl/fdds_ifs.sv =====
interface fdds_in_if;
    logic       valid;
    logic       ready;
    logic       func;
    logic [7:0] first_value;
    logic       first_show;
    logic [7:0] second_value;
    logic       second_show;
    logic       dot_on;

    modport source (
        output valid, func, first_value, first_show, second_value, second_show, dot_on,
        input  ready
    );
    modport sink (
        input  valid, func, first_value, first_show, second_value, second_show, dot_on,
        output ready
    );
endinterface

interface fdds_out_if;
    logic valid;
    logic ready;
    logic clk_level;
    logic dio_level;
    logic busy_res;
    logic load_refused;

    modport source (
        output valid, clk_level, dio_level, busy_res, load_refused,
        input  ready
    );
    modport sink (
        input  valid, clk_level, dio_level, busy_res, load_refused,
        output ready
    );
endinterface

// ===== rtl/fdds_digit_enc.sv =====
module fdds_digit_enc (
    input  logic [7:0] i_value,
    input  logic       i_show,
    output logic [7:0] o_tens_code,
    output logic [7:0] o_units_code
);

    logic [6:0]  sat;
    logic [14:0] prod;
    logic [3:0]  tens;
    logic [6:0]  tens_x10;
    logic [3:0]  units;

    always_comb begin
        sat = (i_value > fdds_pkg::VALUE_MAX) ? fdds_pkg::VALUE_MAX[6:0] : i_value[6:0];
        // divide by ten: n * 205 >> 11 is exact over this range
        prod     = 15'(sat) * 15'd205;
        tens     = prod[14:11];
        tens_x10 = 7'({tens, 3'b000}) + 7'({tens, 1'b0});
        units    = 4'(sat - tens_x10);
        if (i_show) begin
            o_tens_code  = fdds_pkg::seg_code(tens);
            o_units_code = fdds_pkg::seg_code(units);
        end else begin
            o_tens_code  = fdds_pkg::SEG_BLANK;
            o_units_code = fdds_pkg::SEG_BLANK;
        end
    end

endmodule

// ===== rtl/four_digit_display_serializer_unit.sv =====
// Two-wire serial driver for a four-digit seven-segment display controller.
// Each input transaction yields exactly one result transaction carrying the
// clock and data line levels after that item, the busy flag and a refusal
// flag. A load (func=1) taken while idle latches the segment codes and starts
// a refresh: command 0x44, four address/code frame pairs 0xC0..0xC3, then
// 0x88|brightness; a load while busy is dropped and flagged. Tick items
// (func=0) advance time, each line phase holding phase_ticks ticks (0 acts as
// 1). A full refresh is 6*7 + 10*27 = 312 phases. One item is taken every
// clock cycle unless o_res stalls; an item passes the input register, then the
// result register, which loads together with the phase sequencer state.
// Registers: 0x0 phase_ticks (reset 20), 0x4 brightness (reset 0).
module four_digit_display_serializer_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    fdds_in_if.sink                        i_item,
    fdds_out_if.source                     o_res,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [fdds_pkg::ADDR_W-1:0]    paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);

    localparam int unsigned FRAMES = fdds_pkg::DIGITS + 2;
    localparam int unsigned FW     = $clog2(FRAMES);
    localparam int unsigned DW     = $clog2(fdds_pkg::DIGITS);
    localparam logic [FW-1:0] LAST_FRAME = FW'(FRAMES - 1);

    // configuration
    logic [7:0] r_phase_ticks;
    logic [2:0] r_brightness;
    logic       cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_ticks <= fdds_pkg::PHASE_TICKS_RST;
            r_brightness  <= fdds_pkg::BRIGHTNESS_RST;
        end else if (cfg_wr) begin
            if (paddr[2] == fdds_pkg::REG_PHASE_TICKS) begin
                r_phase_ticks <= pwdata[7:0];
            end else begin
                r_brightness <= pwdata[2:0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == fdds_pkg::REG_BRIGHTNESS) begin
            prdata = {29'd0, r_brightness};
        end else begin
            prdata = {24'd0, r_phase_ticks};
        end
    end

    // input register
    logic       r_s1_valid;
    logic       r_func;
    logic [7:0] r_first_value;
    logic       r_first_show;
    logic [7:0] r_second_value;
    logic       r_second_show;
    logic       r_dot_on;
    logic       r_out_valid;
    logic       s2_take;
    logic       in_acc;

    assign s2_take      = r_s1_valid && (!r_out_valid || o_res.ready);
    assign i_item.ready = !r_s1_valid || s2_take;
    assign in_acc       = i_item.valid && i_item.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_acc) begin
            r_s1_valid <= 1'b1;
        end else if (s2_take) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_func         <= i_item.func;
            r_first_value  <= i_item.first_value;
            r_first_show   <= i_item.first_show;
            r_second_value <= i_item.second_value;
            r_second_show  <= i_item.second_show;
            r_dot_on       <= i_item.dot_on;
        end
    end

    // digit encoding
    logic [7:0] enc_code [fdds_pkg::DIGITS];

    fdds_digit_enc u_enc_first (
        .i_value      (r_first_value),
        .i_show       (r_first_show),
        .o_tens_code  (enc_code[0]),
        .o_units_code (enc_code[1])
    );

    fdds_digit_enc u_enc_second (
        .i_value      (r_second_value),
        .i_show       (r_second_show),
        .o_tens_code  (enc_code[2]),
        .o_units_code (enc_code[3])
    );

    // phase sequencer state
    logic [7:0]       r_seg [fdds_pkg::DIGITS];
    logic [7:0]       n_seg [fdds_pkg::DIGITS];
    logic             r_active,  n_active;
    fdds_pkg::t_phase r_phase,   n_phase;
    logic [1:0]       r_step,    n_step;
    logic [3:0]       r_bit,     n_bit;
    logic             r_byte,    n_byte;
    logic [FW-1:0]    r_frame,   n_frame;
    logic [7:0]       r_tick,    n_tick;
    logic             r_clk,     n_clk;
    logic             r_dio,     n_dio;
    logic             n_refused;

    logic [7:0]       hold;
    logic             expire;
    logic             two_byte;
    logic [DW-1:0]    dig_idx;
    logic [7:0]       cur_byte;

    always_comb begin
        n_seg     = r_seg;
        n_active  = r_active;
        n_phase   = r_phase;
        n_step    = r_step;
        n_bit     = r_bit;
        n_byte    = r_byte;
        n_frame   = r_frame;
        n_tick    = r_tick;
        n_clk     = r_clk;
        n_dio     = r_dio;
        n_refused = 1'b0;
        hold      = (r_phase_ticks == 8'd0) ? 8'd1 : r_phase_ticks;
        expire    = ({1'b0, r_tick} + 9'd1) >= {1'b0, hold};
        two_byte  = (r_frame != '0) && (r_frame != LAST_FRAME);
        dig_idx   = '0;
        cur_byte  = '0;

        if (r_func) begin
            if (r_active) begin
                n_refused = 1'b1;
            end else begin
                n_seg[0] = enc_code[0];
                n_seg[1] = r_dot_on ? (enc_code[1] | fdds_pkg::SEG_DOT) : enc_code[1];
                n_seg[2] = enc_code[2];
                n_seg[3] = enc_code[3];
                n_active = 1'b1;
                n_phase  = fdds_pkg::PH_START;
                n_step   = 2'd0;
                n_bit    = 4'd0;
                n_byte   = 1'b0;
                n_frame  = '0;
                n_tick   = 8'd0;
                n_clk    = 1'b1;
                n_dio    = 1'b1;
            end
        end else if (r_active) begin
            if (!expire) begin
                n_tick = r_tick + 8'd1;
            end else begin
                n_tick = 8'd0;
                // advance to the next phase
                case (r_phase)
                    fdds_pkg::PH_START: begin
                        if (r_step != 2'd2) begin
                            n_step = r_step + 2'd1;
                        end else begin
                            n_phase = fdds_pkg::PH_BITS;
                            n_step  = 2'd0;
                            n_bit   = 4'd0;
                            n_byte  = 1'b0;
                        end
                    end
                    fdds_pkg::PH_BITS: begin
                        if (r_step != 2'd2) begin
                            n_step = r_step + 2'd1;
                        end else begin
                            n_step = 2'd0;
                            if (r_bit != 4'd8) begin
                                n_bit = r_bit + 4'd1;
                            end else begin
                                n_bit = 4'd0;
                                if (two_byte && !r_byte) begin
                                    n_byte = 1'b1;
                                end else begin
                                    n_phase = fdds_pkg::PH_STOP;
                                end
                            end
                        end
                    end
                    fdds_pkg::PH_STOP: begin
                        if (r_step != 2'd3) begin
                            n_step = r_step + 2'd1;
                        end else if (r_frame == LAST_FRAME) begin
                            // lines already rest high after the final stop
                            n_active = 1'b0;
                            n_frame  = '0;
                            n_step   = 2'd0;
                            n_phase  = fdds_pkg::PH_START;
                        end else begin
                            n_frame = r_frame + FW'(1);
                            n_phase = fdds_pkg::PH_START;
                            n_step  = 2'd0;
                        end
                    end
                    default: begin
                        n_phase = fdds_pkg::PH_START;
                    end
                endcase

                // byte of the frame being sent in the new phase
                dig_idx = DW'(n_frame - FW'(1));
                if (n_frame == '0) begin
                    cur_byte = fdds_pkg::CMD_DATA;
                end else if (n_frame == LAST_FRAME) begin
                    cur_byte = fdds_pkg::CMD_DISP | {5'd0, r_brightness};
                end else if (n_byte) begin
                    cur_byte = r_seg[dig_idx];
                end else begin
                    cur_byte = fdds_pkg::CMD_ADDR | 8'(dig_idx);
                end

                // drive the lines for the new phase
                if (n_active) begin
                    case (n_phase)
                        fdds_pkg::PH_START: begin
                            if (n_step == 2'd0) begin
                                n_clk = 1'b1;
                                n_dio = 1'b1;
                            end else if (n_step == 2'd1) begin
                                n_dio = 1'b0;
                            end else begin
                                n_clk = 1'b0;
                            end
                        end
                        fdds_pkg::PH_BITS: begin
                            if (n_step == 2'd0) begin
                                n_clk = 1'b0;
                            end else if (n_step == 2'd1) begin
                                // the acknowledge slot after the data bits releases data
                                n_dio = (n_bit == 4'd8) ? 1'b1 : cur_byte[n_bit[2:0]];
                            end else begin
                                n_clk = 1'b1;
                            end
                        end
                        fdds_pkg::PH_STOP: begin
                            case (n_step)
                                2'd0:    n_clk = 1'b0;
                                2'd1:    n_dio = 1'b0;
                                2'd2:    n_clk = 1'b1;
                                default: n_dio = 1'b1;
                            endcase
                        end
                        default: begin
                            n_clk = r_clk;
                        end
                    endcase
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_phase  <= fdds_pkg::PH_START;
            r_step   <= 2'd0;
            r_bit    <= 4'd0;
            r_byte   <= 1'b0;
            r_frame  <= '0;
            r_tick   <= 8'd0;
            r_clk    <= 1'b1;
            r_dio    <= 1'b1;
            for (int i = 0; i < fdds_pkg::DIGITS; i++) begin
                r_seg[i] <= fdds_pkg::SEG_BLANK;
            end
        end else if (s2_take) begin
            r_active <= n_active;
            r_phase  <= n_phase;
            r_step   <= n_step;
            r_bit    <= n_bit;
            r_byte   <= n_byte;
            r_frame  <= n_frame;
            r_tick   <= n_tick;
            r_clk    <= n_clk;
            r_dio    <= n_dio;
            r_seg    <= n_seg;
        end
    end

    // result register
    fdds_pkg::t_result r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s2_take) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_take) begin
            r_res.clk_level    <= n_clk;
            r_res.dio_level    <= n_dio;
            r_res.busy_res     <= n_active;
            r_res.load_refused <= n_refused;
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.clk_level    = r_res.clk_level;
    assign o_res.dio_level    = r_res.dio_level;
    assign o_res.busy_res     = r_res.busy_res;
    assign o_res.load_refused = r_res.load_refused;

endmodule

// ===== tb/four_digit_display_serializer_unit_test.sv =====
`timescale 1ns / 1ps

module four_digit_display_serializer_unit_test;

    typedef enum logic {
        FN_TICK = 1'b0,
        FN_LOAD = 1'b1
    } t_func;

    typedef struct packed {
        logic       func;
        logic [7:0] first_value;
        logic       first_show;
        logic [7:0] second_value;
        logic       second_show;
        logic       dot_on;
    } t_item;

    typedef enum logic [1:0] {
        ROW_SEND,
        ROW_SET_TICKS,
        ROW_SET_BRIGHT
    } t_row_kind;

    // reps of zero: keep ticking until the refresh run is over
    typedef struct packed {
        t_row_kind         kind;
        t_item             it;
        logic [15:0]       reps;
        logic              typed;
        fdds_pkg::t_result want;
        logic [7:0]        cfg;
    } t_row;

    typedef struct packed {
        logic [7:0]  ticks;
        logic [2:0]  bright;
        logic [6:0]  gap_pct;
        logic [6:0]  stall_pct;
        logic [15:0] items;
        logic        hold_off;
    } t_soak;

    localparam int unsigned FRAME_COUNT     = 6;
    localparam int unsigned PHASES_PER_BYTE = 27;
    localparam int unsigned FRAME_OVERHEAD  = 7;
    localparam int unsigned HOLD_OFF_CYCLES = 250;

    localparam logic [7:0] BUS_CMD_DATA    = 8'h44;
    localparam logic [7:0] BUS_CMD_ADDR    = 8'hc0;
    localparam logic [7:0] BUS_CMD_DISPLAY = 8'h88;
    localparam logic [7:0] GLYPH_BLANK     = 8'h00;
    localparam logic [7:0] GLYPH_DOT       = 8'h80;

    localparam logic [7:0] DIGIT_GLYPH [0:9] = '{
        8'h3f, 8'h06, 8'h5b, 8'h4f, 8'h66, 8'h6d, 8'h7d, 8'h07, 8'h7f, 8'h6f
    };

    localparam t_row DIR_PLAN [0:23] = '{
        '{ROW_SEND, '{FN_TICK, 8'd0, 1'b0, 8'd0, 1'b0, 1'b0}, 16'd1, 1'b1, 4'b1100, 8'd0},
        '{ROW_SEND, '{FN_LOAD, 8'd255, 1'b1, 8'd0, 1'b1, 1'b1}, 16'd1, 1'b1, 4'b1110, 8'd0},
        '{ROW_SEND, '{FN_LOAD, 8'd0, 1'b1, 8'd0, 1'b1, 1'b0}, 16'd1, 1'b1, 4'b1111, 8'd0},
        '{ROW_SEND, '{FN_TICK, 8'd0, 1'b0, 8'd0, 1'b0, 1'b0}, 16'd19, 1'b0, 4'b0000, 8'd0},
        '{ROW_SEND, '{FN_TICK, 8'd0, 1'b0, 8'd0, 1'b0, 1'b0}, 16'd1, 1'b1, 4'b1010, 8'd0},
        '{ROW_SET_TICKS, '0, 16'd0, 1'b0, 4'b0000, 8'd0},
        '{ROW_SET_BRIGHT, '0, 16'd0, 1'b0, 4'b0000, 8'd7},
        '{ROW_SEND, '{FN_TICK, 8'd0, 1'b0, 8'd0, 1'b0, 1'b0}, 16'd0, 1'b0, 4'b0000, 8'd0},
        '{ROW_SEND, '{FN_TICK, 8'hff, 1'b1, 8'hff, 1'b1, 1'b1}, 16'd1, 1'b1, 4'b1100, 8'd0},
        '{ROW_SET_TICKS, '0, 16'd0, 1'b0, 4'b0000, 8'd1},
        '{ROW_SEND, '{FN_LOAD, 8'd99, 1'b1, 8'd100, 1'b1, 1'b0}, 16'd1, 1'b1, 4'b1110, 8'd0},
        '{ROW_SEND, '{FN_TICK, 8'd0, 1'b0, 8'd0, 1'b0, 1'b0}, 16'd0, 1'b0, 4'b0000, 8'd0},
        '{ROW_SEND, '{FN_LOAD, 8'd0, 1'b0, 8'd255, 1'b0, 1'b1}, 16'd1, 1'b1, 4'b1110, 8'd0},
        '{ROW_SET_BRIGHT, '0, 16'd0, 1'b0, 4'b0000, 8'd0},
        '{ROW_SEND, '{FN_TICK, 8'd0, 1'b0, 8'd0, 1'b0, 1'b0}, 16'd0, 1'b0, 4'b0000, 8'd0},
        '{ROW_SET_TICKS, '0, 16'd0, 1'b0, 4'b0000, 8'd2},
        '{ROW_SEND, '{FN_LOAD, 8'd42, 1'b1, 8'd7, 1'b1, 1'b0}, 16'd1, 1'b0, 4'b0000, 8'd0},
        '{ROW_SEND, '{FN_TICK, 8'd0, 1'b0, 8'd0, 1'b0, 1'b0}, 16'd0, 1'b0, 4'b0000, 8'd0},
        '{ROW_SET_TICKS, '0, 16'd0, 1'b0, 4'b0000, 8'd255},
        '{ROW_SET_BRIGHT, '0, 16'd0, 1'b0, 4'b0000, 8'd3},
        '{ROW_SEND, '{FN_LOAD, 8'd10, 1'b1, 8'd9, 1'b1, 1'b1}, 16'd1, 1'b1, 4'b1110, 8'd0},
        '{ROW_SEND, '{FN_TICK, 8'd0, 1'b0, 8'd0, 1'b0, 1'b0}, 16'd600, 1'b0, 4'b0000, 8'd0},
        '{ROW_SET_TICKS, '0, 16'd0, 1'b0, 4'b0000, 8'd1},
        '{ROW_SEND, '{FN_TICK, 8'd0, 1'b0, 8'd0, 1'b0, 1'b0}, 16'd0, 1'b0, 4'b0000, 8'd0}
    };

    localparam t_soak SOAK_PLAN [0:6] = '{
        '{8'd1,   3'd5, 7'd0,  7'd0,  16'd350, 1'b1},
        '{8'd1,   3'd7, 7'd54, 7'd0,  16'd300, 1'b0},
        '{8'd3,   3'd0, 7'd0,  7'd54, 16'd300, 1'b0},
        '{8'd1,   3'd2, 7'd29, 7'd29, 16'd300, 1'b0},
        '{8'd255, 3'd4, 7'd0,  7'd0,  16'd150, 1'b0},
        '{8'd2,   3'd6, 7'd29, 7'd29, 16'd200, 1'b0},
        '{8'd1,   3'd1, 7'd0,  7'd0,  16'd150, 1'b0}
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [fdds_pkg::ADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    fdds_in_if  item_if ();
    fdds_out_if res_if ();

    four_digit_display_serializer_unit u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (item_if),
        .o_res   (res_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #5 i_clk = ~i_clk;

    // Display state as the block should hold it
    logic [7:0]  cfg_ticks;
    logic [2:0]  cfg_bright;
    logic [7:0]  glyphs [0:3];
    int unsigned seq_frame;
    int unsigned seq_phase;
    int unsigned hold_count;
    logic        ln_clk;
    logic        ln_dio;
    logic        seq_active;

    fdds_pkg::t_result display_q [$];
    int unsigned sender_gap_pct;
    int unsigned receiver_stall_pct;
    bit          holdoff_pending;
    int unsigned error_count;
    int unsigned items_sent;
    int unsigned results_checked;
    int unsigned loads_started;
    int unsigned loads_refused;
    int unsigned runs_completed;

    function automatic int unsigned bytes_in(input int unsigned f);
        return (f >= 1 && f <= 4) ? 2 : 1;
    endfunction

    function automatic int unsigned frame_len(input int unsigned f);
        return FRAME_OVERHEAD + PHASES_PER_BYTE * bytes_in(f);
    endfunction

    function automatic logic [7:0] frame_byte(input int unsigned f, input int unsigned b);
        if (f == 0)
            return BUS_CMD_DATA;
        if (f <= 4)
            return (b == 0) ? BUS_CMD_ADDR + 8'(f - 1) : glyphs[f - 1];
        return BUS_CMD_DISPLAY | {5'd0, cfg_bright};
    endfunction

    function automatic void drive_phase(input int unsigned f, input int unsigned p);
        int unsigned nb;
        int unsigned q;
        int unsigned bit_no;
        int unsigned sub;
        logic [7:0]  byte_out;
        nb = bytes_in(f);
        if (p < 3) begin
            if (p == 0) begin
                ln_clk = 1'b1;
                ln_dio = 1'b1;
            end else if (p == 1) begin
                ln_dio = 1'b0;
            end else begin
                ln_clk = 1'b0;
            end
            return;
        end
        q = p - 3;
        if (q < PHASES_PER_BYTE * nb) begin
            bit_no = (q % PHASES_PER_BYTE) / 3;
            sub    = (q % PHASES_PER_BYTE) % 3;
            if (sub == 0) begin
                ln_clk = 1'b0;
            end else if (sub == 2) begin
                ln_clk = 1'b1;
            end else if (bit_no < 8) begin
                byte_out = frame_byte(f, q / PHASES_PER_BYTE);
                ln_dio = byte_out[bit_no];
            end else begin
                // acknowledge slot: release data
                ln_dio = 1'b1;
            end
            return;
        end
        q = q - PHASES_PER_BYTE * nb;
        case (q)
            0:       ln_clk = 1'b0;
            1:       ln_dio = 1'b0;
            2:       ln_clk = 1'b1;
            default: ln_dio = 1'b1;
        endcase
    endfunction

    function automatic void latch_pair(input logic [7:0] value, input logic show,
                                       input int unsigned slot);
        int unsigned n;
        n = (value > 8'd99) ? 99 : int'(value);
        glyphs[slot]     = show ? DIGIT_GLYPH[n / 10] : GLYPH_BLANK;
        glyphs[slot + 1] = show ? DIGIT_GLYPH[n % 10] : GLYPH_BLANK;
    endfunction

    function automatic fdds_pkg::t_result advance_display(input t_item it);
        fdds_pkg::t_result r;
        int unsigned       hold;
        r.load_refused = 1'b0;
        if (it.func == FN_LOAD) begin
            if (seq_active) begin
                r.load_refused = 1'b1;
                loads_refused++;
            end else begin
                latch_pair(it.first_value, it.first_show, 0);
                latch_pair(it.second_value, it.second_show, 2);
                if (it.dot_on)
                    glyphs[1] = glyphs[1] | GLYPH_DOT;
                seq_active = 1'b1;
                seq_frame  = 0;
                seq_phase  = 0;
                hold_count = 0;
                drive_phase(0, 0);
                loads_started++;
            end
        end else if (seq_active) begin
            hold = (cfg_ticks == 8'd0) ? 1 : int'(cfg_ticks);
            if (hold_count + 1 >= hold) begin
                hold_count = 0;
                seq_phase++;
                if (seq_phase >= frame_len(seq_frame)) begin
                    seq_phase = 0;
                    seq_frame++;
                    if (seq_frame >= FRAME_COUNT) begin
                        seq_frame  = 0;
                        seq_active = 1'b0;
                        runs_completed++;
                    end
                end
                if (seq_active)
                    drive_phase(seq_frame, seq_phase);
            end else begin
                hold_count++;
            end
        end
        r.clk_level = ln_clk;
        r.dio_level = ln_dio;
        r.busy_res  = seq_active;
        return r;
    endfunction

    function automatic logic [7:0] pick_value();
        case ($urandom_range(3))
            0:       return 8'($urandom_range(255));
            1:       return 8'($urandom_range(99));
            2: begin
                case ($urandom_range(5))
                    0:       return 8'd0;
                    1:       return 8'd9;
                    2:       return 8'd10;
                    3:       return 8'd99;
                    4:       return 8'd100;
                    default: return 8'd255;
                endcase
            end
            default: return 8'($urandom_range(110, 90));
        endcase
    endfunction

    // Mostly complete refresh runs; stray loads while busy act as noise
    function automatic t_item random_item();
        t_item       it;
        logic [31:0] raw;
        raw = $urandom;
        it = raw[$bits(t_item)-1:0];
        if (seq_active)
            it.func = ($urandom_range(99) < 2) ? FN_LOAD : FN_TICK;
        else
            it.func = ($urandom_range(99) < 80) ? FN_LOAD : FN_TICK;
        if (it.func == FN_LOAD) begin
            it.first_value  = pick_value();
            it.second_value = pick_value();
            it.first_show   = ($urandom_range(99) < 85);
            it.second_show  = ($urandom_range(99) < 85);
        end
        return it;
    endfunction

    task automatic send_item(input t_item it, input bit typed, input fdds_pkg::t_result want,
                             output bit effective);
        fdds_pkg::t_result predicted;
        while ($urandom_range(99) < sender_gap_pct) begin
            item_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        item_if.valid        <= 1'b1;
        item_if.func         <= it.func;
        item_if.first_value  <= it.first_value;
        item_if.first_show   <= it.first_show;
        item_if.second_value <= it.second_value;
        item_if.second_show  <= it.second_show;
        item_if.dot_on       <= it.dot_on;
        do @(posedge i_clk); while (!item_if.ready);
        effective = (it.func == FN_LOAD) ? !seq_active : seq_active;
        predicted = advance_display(it);
        display_q.push_back(typed ? want : predicted);
        items_sent++;
    endtask

    // Drain, then write the register and read it back
    task automatic configure(input logic reg_idx, input logic [7:0] value);
        int acc;
        item_if.valid <= 1'b0;
        while (display_q.size() != 0)
            @(posedge i_clk);
        @(posedge i_clk);
        for (acc = 0; acc < 2; acc++) begin
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= (acc == 0);
            paddr   <= {reg_idx, 2'b00};
            pwdata  <= {24'd0, value};
            @(posedge i_clk);
            penable <= 1'b1;
            do @(posedge i_clk); while (!pready);
            if (acc == 1 && prdata !== {24'd0, value}) begin
                $error("register %0d read back: expected %0h, got %0h", reg_idx, value, prdata);
                error_count++;
            end
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        if (reg_idx == fdds_pkg::REG_PHASE_TICKS)
            cfg_ticks = value;
        else
            cfg_bright = value[2:0];
    endtask

    initial begin : result_checker
        fdds_pkg::t_result got;
        fdds_pkg::t_result want;
        int unsigned       holdoff_left;
        holdoff_left = 0;
        res_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (res_if.valid && res_if.ready) begin
                got = {res_if.clk_level, res_if.dio_level, res_if.busy_res, res_if.load_refused};
                if (display_q.size() == 0) begin
                    $error("result transaction with nothing expected: %b", got);
                    error_count++;
                end else begin
                    want = display_q.pop_front();
                    results_checked++;
                    if (got.clk_level !== want.clk_level) begin
                        $error("clk_level: expected %0b, got %0b", want.clk_level, got.clk_level);
                        error_count++;
                    end
                    if (got.dio_level !== want.dio_level) begin
                        $error("dio_level: expected %0b, got %0b", want.dio_level, got.dio_level);
                        error_count++;
                    end
                    if (got.busy_res !== want.busy_res) begin
                        $error("busy_res: expected %0b, got %0b", want.busy_res, got.busy_res);
                        error_count++;
                    end
                    if (got.load_refused !== want.load_refused) begin
                        $error("load_refused: expected %0b, got %0b",
                               want.load_refused, got.load_refused);
                        error_count++;
                    end
                end
            end
            if (holdoff_pending && holdoff_left == 0) begin
                holdoff_pending = 1'b0;
                holdoff_left = HOLD_OFF_CYCLES;
            end
            // hold ready low through the hold-off so the block backs up
            if (!i_rst_n || holdoff_left != 0) begin
                res_if.ready <= 1'b0;
                if (holdoff_left != 0)
                    holdoff_left--;
            end else begin
                res_if.ready <= ($urandom_range(99) >= receiver_stall_pct);
            end
        end
    end

    initial begin
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        t_row        row;
        bit          eff;
        int unsigned done;
        int          k;
        i_rst_n              = 1'b0;
        item_if.valid        = 1'b0;
        item_if.func         = FN_TICK;
        item_if.first_value  = 8'd0;
        item_if.first_show   = 1'b0;
        item_if.second_value = 8'd0;
        item_if.second_show  = 1'b0;
        item_if.dot_on       = 1'b0;
        psel                 = 1'b0;
        penable              = 1'b0;
        pwrite               = 1'b0;
        paddr                = '0;
        pwdata               = 32'd0;
        sender_gap_pct       = 0;
        receiver_stall_pct   = 0;
        holdoff_pending      = 1'b0;
        error_count          = 0;
        items_sent           = 0;
        results_checked      = 0;
        loads_started        = 0;
        loads_refused        = 0;
        runs_completed       = 0;
        cfg_ticks            = 8'd20;
        cfg_bright           = 3'd0;
        for (k = 0; k < 4; k++)
            glyphs[k] = GLYPH_BLANK;
        seq_frame  = 0;
        seq_phase  = 0;
        hold_count = 0;
        ln_clk     = 1'b1;
        ln_dio     = 1'b1;
        seq_active = 1'b0;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (k = 0; k < $size(DIR_PLAN); k++) begin
            row = DIR_PLAN[k];
            case (row.kind)
                ROW_SEND: begin
                    if (row.reps == 16'd0) begin
                        do send_item(row.it, 1'b0, '0, eff); while (seq_active);
                    end else begin
                        repeat (row.reps) send_item(row.it, row.typed, row.want, eff);
                    end
                end
                ROW_SET_TICKS:  configure(fdds_pkg::REG_PHASE_TICKS, row.cfg);
                default:        configure(fdds_pkg::REG_BRIGHTNESS, row.cfg);
            endcase
        end

        for (k = 0; k < $size(SOAK_PLAN); k++) begin
            configure(fdds_pkg::REG_PHASE_TICKS, SOAK_PLAN[k].ticks);
            configure(fdds_pkg::REG_BRIGHTNESS, {5'd0, SOAK_PLAN[k].bright});
            sender_gap_pct     = SOAK_PLAN[k].gap_pct;
            receiver_stall_pct = SOAK_PLAN[k].stall_pct;
            holdoff_pending    = SOAK_PLAN[k].hold_off;
            done = 0;
            while (done < SOAK_PLAN[k].items) begin
                send_item(random_item(), 1'b0, '0, eff);
                done += eff;
            end
        end

        item_if.valid <= 1'b0;
        while (display_q.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("%0d transactions sent, %0d results checked; %0d refresh runs finished,",
                 items_sent, results_checked, runs_completed);
        $display("%0d loads started and %0d refused, phase hold 0..255, brightness 0..7",
                 loads_started, loads_refused);
        if (error_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
